// File: src/sofr_pkg.sv
// ----------------------------------------------------------------------------
// sofr_pkg: frame receiver shared definitions
// Parse phases, event kinds, register indexes and the result word type.
// ----------------------------------------------------------------------------
package sofr_pkg;

  // parse phases
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_CMD  = 2'd1;
  localparam logic [1:0] PHASE_LEN  = 2'd2;
  localparam logic [1:0] PHASE_DATA = 2'd3;

  // event kinds
  localparam logic [1:0] EV_ACK    = 2'd0;
  localparam logic [1:0] EV_NACK   = 2'd1;
  localparam logic [1:0] EV_STATUS = 2'd2;
  localparam logic [1:0] EV_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_START_MARKER = 3'd0;
  localparam logic [2:0] REG_END_MARKER   = 3'd1;
  localparam logic [2:0] REG_ACK_CODE     = 3'd2;
  localparam logic [2:0] REG_NACK_CODE    = 3'd3;
  localparam logic [2:0] REG_STATUS_CODE  = 3'd4;
  localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd5;

  localparam int unsigned HEADER_BYTES = 3;
  localparam int unsigned HEAD_DEPTH   = 4;
  localparam int unsigned ACK_MIN_LEN  = 2;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [7:0] charge_state;
    logic [7:0] light_state;
    logic [7:0] angle_state;
    logic [7:0] fan_state;
  } result_t;

endpackage

// File: src/sof_len_eof_frame_receiver.sv
// ----------------------------------------------------------------------------
// sof_len_eof_frame_receiver: serial frame parser
// Parses start, command, length, data, end frames one byte at a time and
// reports ack, nack and status report events.
// ----------------------------------------------------------------------------
//  channel  | handshake                        | payload
//  ---------+----------------------------------+------------------------------
//  rx in    | in_valid_i / in_stall_o          | rx_data_i
//  event out| out_valid_o / out_stall_i        | event_kind_o .. fan_state_o
//  config   | cfg_we_i                         | cfg_idx_i, cfg_wdata_i
//
//  One byte is taken per cycle while in_stall_o is low; parse and state update
//  finish in the cycle of acceptance; the event word is registered in out_q.
//  The output register plus one skid word keep input flowing while the output
//  is stalled; in_stall_o rises only when the skid word is occupied.
//  Async reset (rst_ni low): idle, stored values zero, config regs at defaults.
module sof_len_eof_frame_receiver
  import sofr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] arg_first_o,
  output logic [7:0] arg_second_o,
  output logic [7:0] charge_state_o,
  output logic [7:0] light_state_o,
  output logic [7:0] angle_state_o,
  output logic [7:0] fan_state_o
);

  logic [7:0] start_marker_q, end_marker_q, ack_code_q, nack_code_q;
  logic [7:0] status_code_q, max_payload_q;

  logic [1:0] phase_q, phase_d;
  logic [8:0] pos_q, pos_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] head_q [HEAD_DEPTH];
  logic [7:0] head_d [HEAD_DEPTH];
  logic [7:0] stat_q [4];
  logic [7:0] stat_d [4];

  logic       in_accept;
  logic       res_valid;
  result_t    res;
  logic [8:0] data_idx;
  logic [8:0] pos_inc;
  logic       frame_done;

  logic       out_valid_q, skid_valid_q, out_take;
  result_t    out_q, skid_q;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i & ~skid_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= 8'd170;
      end_marker_q   <= 8'd85;
      ack_code_q     <= 8'd129;
      nack_code_q    <= 8'd130;
      status_code_q  <= 8'd131;
      max_payload_q  <= 8'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_MARKER: start_marker_q <= cfg_wdata_i;
        REG_END_MARKER:   end_marker_q   <= cfg_wdata_i;
        REG_ACK_CODE:     ack_code_q     <= cfg_wdata_i;
        REG_NACK_CODE:    nack_code_q    <= cfg_wdata_i;
        REG_STATUS_CODE:  status_code_q  <= cfg_wdata_i;
        REG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign data_idx   = pos_q - 9'(HEADER_BYTES);
  assign pos_inc    = pos_q + 9'd1;
  assign frame_done = {1'b0, pos_inc} >= ({2'b00, len_q} + 10'(HEADER_BYTES + 1));

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    head_d    = head_q;
    stat_d    = stat_q;
    res_valid = 1'b0;
    res       = '{event_kind: EV_NONE, default: '0};
    if (in_accept) begin
      case (phase_q)
        PHASE_IDLE: begin
          if (rx_data_i == start_marker_q) begin
            phase_d = PHASE_CMD;
            pos_d   = 9'd1;
          end
        end
        PHASE_CMD: begin
          cmd_d   = rx_data_i;
          pos_d   = 9'd2;
          phase_d = PHASE_LEN;
        end
        PHASE_LEN: begin
          len_d = rx_data_i;
          if (rx_data_i > max_payload_q) begin
            phase_d = PHASE_IDLE;
            pos_d   = 9'd0;
          end else begin
            phase_d = PHASE_DATA;
            pos_d   = 9'(HEADER_BYTES);
          end
        end
        default: begin
          // keep only the head of the data; the end byte lands there on short frames
          if (data_idx < 9'(HEAD_DEPTH)) begin
            head_d[data_idx[1:0]] = rx_data_i;
          end
          pos_d = pos_inc;
          if (frame_done) begin
            phase_d = PHASE_IDLE;
            pos_d   = 9'd0;
            if (rx_data_i == end_marker_q) begin
              if (cmd_q == ack_code_q) begin
                if (len_q >= 8'(ACK_MIN_LEN)) begin
                  res_valid      = 1'b1;
                  res.event_kind = EV_ACK;
                end
              end else if (cmd_q == nack_code_q) begin
                if (len_q >= 8'(ACK_MIN_LEN)) begin
                  res_valid      = 1'b1;
                  res.event_kind = EV_NACK;
                end
              end else if (cmd_q == status_code_q) begin
                if (len_q >= 8'(HEAD_DEPTH)) begin
                  res_valid      = 1'b1;
                  res.event_kind = EV_STATUS;
                  stat_d         = head_d;
                end
              end
            end
          end
        end
      endcase
    end
    if (res.event_kind != EV_STATUS) begin
      res.arg_first  = head_d[0];
      res.arg_second = head_d[1];
    end
    res.charge_state = stat_d[0];
    res.light_state  = stat_d[1];
    res.angle_state  = stat_d[2];
    res.fan_state    = stat_d[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_IDLE;
      pos_q   <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      head_q  <= '{default: '0};
      stat_q  <= '{default: '0};
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      head_q  <= head_d;
      stat_q  <= stat_d;
    end
  end

  // output register with one skid word
  assign out_take = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_take) begin
      out_q <= res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_q.event_kind;
  assign arg_first_o    = out_q.arg_first;
  assign arg_second_o   = out_q.arg_second;
  assign charge_state_o = out_q.charge_state;
  assign light_state_o  = out_q.light_state;
  assign angle_state_o  = out_q.angle_state;
  assign fan_state_o    = out_q.fan_state;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");

  a_idle_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PHASE_IDLE) |-> (pos_q == 9'd0))
    else $error("byte position not cleared while idle");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.event_kind != EV_NONE))
    else $error("output word carries no event kind");

  a_status_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !skid_valid_q && out_q.event_kind == EV_STATUS) |->
      (out_q.charge_state == stat_q[0] && out_q.fan_state == stat_q[3]))
    else $error("status event differs from stored status");

endmodule
